/* sv/limited_shortest_angle_difference_unit_macros.svh */
// assertion macros shared by the checker of the angle difference unit
`ifndef LIMITED_SHORTEST_ANGLE_DIFFERENCE_UNIT_MACROS_SVH
`define LIMITED_SHORTEST_ANGLE_DIFFERENCE_UNIT_MACROS_SVH

// checked only while out of reset
`define LSAD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LSAD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lsad_pkg.sv */
// shared constants, types and helpers of the angle difference unit
package lsad_pkg;

    localparam int ANGLE_WIDTH   = 24;
    localparam int LIMIT_WIDTH   = 19;
    localparam int DIFF_WIDTH    = 18;
    localparam int TURN_BITS_DEF = 16;

    localparam int S_TDATA_WIDTH = 2 * ANGLE_WIDTH;
    localparam int M_TDATA_WIDTH = ((DIFF_WIDTH + 7) / 8) * 8;

    localparam logic signed [LIMIT_WIDTH-1:0] LOWER_RESET = -19'sd32768;
    localparam logic signed [LIMIT_WIDTH-1:0] UPPER_RESET = 19'sd32768;

    // configuration register indexes
    localparam logic CFG_LOWER_LIMIT = 1'b0;
    localparam logic CFG_UPPER_LIMIT = 1'b1;

    // working width: holds any input angle and a few turns of headroom
    function automatic int work_width(input int turn_bits);
        int a;
        int b;
        a = ANGLE_WIDTH + 1;
        b = turn_bits + 4;
        return (a > b) ? a : b;
    endfunction

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

endpackage

/* sv/lsad_place.sv */
// three-stage reduction and window placement of one angle
module lsad_place
    import lsad_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  logic                                   aclk,
    input  pipe_en_t                               en,
    input  logic signed [ANGLE_WIDTH-1:0]          angle_in,
    input  logic signed [LIMIT_WIDTH-1:0]          lower_limit,
    input  logic signed [LIMIT_WIDTH-1:0]          upper_limit,
    output logic signed [work_width(TURN_BITS)-1:0] angle_out
);

    localparam int W = work_width(TURN_BITS);
    localparam logic signed [W-1:0] TURN =
        {{(W-TURN_BITS-1){1'b0}}, 1'b1, {TURN_BITS{1'b0}}};
    localparam logic signed [W-1:0] TURN_M1 =
        {{(W-TURN_BITS){1'b0}}, {TURN_BITS{1'b1}}};

    logic signed [W-1:0] ax;
    logic [TURN_BITS-1:0] low;
    logic signed [W-1:0] lo_x;
    logic signed [W-1:0] hi_x;
    logic signed [W-1:0] red_next,   red_reg;
    logic signed [W-1:0] upper_next, upper_reg;
    logic signed [W-1:0] lower_next, lower_reg;
    logic signed [W-1:0] x_up;
    logic signed [W-1:0] x_lo;

    assign lo_x = {{(W-LIMIT_WIDTH){lower_limit[LIMIT_WIDTH-1]}}, lower_limit};
    assign hi_x = {{(W-LIMIT_WIDTH){upper_limit[LIMIT_WIDTH-1]}}, upper_limit};

    // truncating remainder by one turn, only when magnitude exceeds a turn
    always_comb begin
        ax  = {{(W-ANGLE_WIDTH){angle_in[ANGLE_WIDTH-1]}}, angle_in};
        low = ax[TURN_BITS-1:0];
        if (ax > TURN || ax < -TURN) begin
            if (ax[W-1] && (low != '0)) begin
                red_next = $signed({{(W-TURN_BITS){1'b0}}, low}) - TURN;
            end else begin
                red_next = $signed({{(W-TURN_BITS){1'b0}}, low});
            end
        end else begin
            red_next = ax;
        end
    end

    // move down by whole turns until at or below the upper limit
    always_comb begin
        x_up = red_reg - hi_x + TURN_M1;
        if (red_reg > hi_x) begin
            upper_next = red_reg - $signed({x_up[W-1:TURN_BITS], {TURN_BITS{1'b0}}});
        end else begin
            upper_next = red_reg;
        end
    end

    // move up by whole turns until at or above the lower limit
    always_comb begin
        x_lo = lo_x - upper_reg + TURN_M1;
        if (upper_reg < lo_x) begin
            lower_next = upper_reg + $signed({x_lo[W-1:TURN_BITS], {TURN_BITS{1'b0}}});
        end else begin
            lower_next = upper_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) red_reg   <= red_next;
        if (en.s2) upper_reg <= upper_next;
        if (en.s3) lower_reg <= lower_next;
    end

    assign angle_out = lower_reg;

endmodule

/* sv/lsad_diff.sv */
// window check, wrapped difference and path selection (two stages)
module lsad_diff
    import lsad_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  logic                                   aclk,
    input  pipe_en_t                               en,
    input  logic                                   operation,
    input  logic signed [work_width(TURN_BITS)-1:0] first_placed,
    input  logic signed [work_width(TURN_BITS)-1:0] second_placed,
    input  logic signed [LIMIT_WIDTH-1:0]          lower_limit,
    input  logic signed [LIMIT_WIDTH-1:0]          upper_limit,
    output logic signed [DIFF_WIDTH-1:0]           difference,
    output logic                                   out_of_limits
);

    localparam int W = work_width(TURN_BITS);
    localparam logic signed [W-1:0] TURN =
        {{(W-TURN_BITS-1){1'b0}}, 1'b1, {TURN_BITS{1'b0}}};
    localparam logic signed [W-1:0] HALF =
        {{(W-TURN_BITS){1'b0}}, 1'b1, {(TURN_BITS-1){1'b0}}};

    logic signed [W-1:0] lo_x;
    logic signed [W-1:0] hi_x;
    logic signed [W-1:0] raw_diff;
    logic signed [W-1:0] wrapped;
    logic signed [W-1:0] sum;
    logic signed [W-1:0] res;
    logic                leave;

    logic                err_next,  err_reg;
    logic                op_next,   op_reg;
    logic signed [W-1:0] d_next,    d_reg;
    logic signed [W-1:0] mag_next,  mag_reg;
    logic signed [W-1:0] alt_next,  alt_reg;
    logic signed [W-1:0] base_next, base_reg;

    logic signed [DIFF_WIDTH-1:0] difference_next, difference_reg;
    logic                         ool_next,        ool_reg;

    assign lo_x = {{(W-LIMIT_WIDTH){lower_limit[LIMIT_WIDTH-1]}}, lower_limit};
    assign hi_x = {{(W-LIMIT_WIDTH){upper_limit[LIMIT_WIDTH-1]}}, upper_limit};

    // shortest difference in (-half, half], half turn counts as positive
    always_comb begin
        err_next = (first_placed < lo_x) || (first_placed > hi_x) ||
                   (second_placed < lo_x) || (second_placed > hi_x);
        raw_diff = first_placed - second_placed;
        wrapped  = $signed({{(W-TURN_BITS){1'b0}}, raw_diff[TURN_BITS-1:0]});
        d_next   = (wrapped > HALF) ? (wrapped - TURN) : wrapped;
        mag_next = d_next[W-1] ? -d_next : d_next;
        alt_next = TURN - mag_next;
        op_next   = operation;
        base_next = second_placed;
    end

    // take the long way when the short one would leave the window
    always_comb begin
        sum   = base_reg + d_reg;
        leave = (sum > hi_x) || (sum < lo_x);
        if (err_reg) begin
            res = '0;
        end else if (leave) begin
            if (op_reg) res = alt_reg;
            else        res = (d_reg > 0) ? -alt_reg : alt_reg;
        end else begin
            res = op_reg ? mag_reg : d_reg;
        end
        difference_next = res[DIFF_WIDTH-1:0];
        ool_next        = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            err_reg  <= err_next;
            op_reg   <= op_next;
            d_reg    <= d_next;
            mag_reg  <= mag_next;
            alt_reg  <= alt_next;
            base_reg <= base_next;
        end
        if (en.s5) begin
            difference_reg <= difference_next;
            ool_reg        <= ool_next;
        end
    end

    assign difference    = difference_reg;
    assign out_of_limits = ool_reg;

endmodule

/* sv/limited_shortest_angle_difference_unit.sv */
// top level of the joint-limited shortest angle difference unit
//
// usage
// - s_ channel: one transaction carries two joint angles (one turn is
//   2^TURN_BITS units) and in s_tuser the operation: 0 signed difference,
//   1 unsigned distance
// - m_ channel: one transaction per input transaction, in order, with the
//   difference (zero on error) and in m_tuser the out-of-limits flag
// - cfg port: cfg_wr_en writes cfg_wdata into lower limit (index 0) or
//   upper limit (index 1) at that clock edge; write only while idle
// - pipeline: m_tvalid rises once a transaction has passed the five register
//   stages: reduce, upper placement, lower placement, wrapped difference,
//   path select/output; one transaction per cycle is sustained while
//   m_tready stays high
// - each stage has its own valid bit and loads whenever it is empty or the
//   next stage moves, so bubbles are squeezed out during a stall
// - when m_tready is low the output holds; s_tready drops only once all
//   five stages hold transactions
// - synchronous active-low reset empties the pipeline and restores the
//   limits to -32768 and 32768
module limited_shortest_angle_difference_unit
    import lsad_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,   // [23:0] first_angle, [47:24] second_angle
    input  logic [0:0]                s_tuser,   // [0] operation
    // result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_WIDTH-1:0]  m_tdata,   // [17:0] difference, [23:18] zero
    output logic [0:0]                m_tuser,   // [0] out_of_limits
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [LIMIT_WIDTH-1:0]    cfg_wdata
);

    localparam int W = work_width(TURN_BITS);

    logic signed [LIMIT_WIDTH-1:0] lower_limit_reg, lower_limit_next;
    logic signed [LIMIT_WIDTH-1:0] upper_limit_reg, upper_limit_next;

    // valid bit of each stage
    logic [5:1] valid_reg, valid_next;
    // operation rides along through the placement stages
    logic [3:1] op_reg, op_next;

    pipe_en_t en;

    logic signed [W-1:0] first_placed;
    logic signed [W-1:0] second_placed;
    logic signed [DIFF_WIDTH-1:0] difference;
    logic out_of_limits;

    // configuration writes
    always_comb begin
        lower_limit_next = lower_limit_reg;
        upper_limit_next = upper_limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LOWER_LIMIT: lower_limit_next = cfg_wdata;
                CFG_UPPER_LIMIT: upper_limit_next = cfg_wdata;
                default:         lower_limit_next = lower_limit_reg;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en.s5 = !valid_reg[5] || m_tready;
        en.s4 = !valid_reg[4] || en.s5;
        en.s3 = !valid_reg[3] || en.s4;
        en.s2 = !valid_reg[2] || en.s3;
        en.s1 = !valid_reg[1] || en.s2;
    end

    always_comb begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (en.s1) begin
            valid_next[1] = s_tvalid;
            op_next[1]    = s_tuser[0];
        end
        if (en.s2) begin
            valid_next[2] = valid_reg[1];
            op_next[2]    = op_reg[1];
        end
        if (en.s3) begin
            valid_next[3] = valid_reg[2];
            op_next[3]    = op_reg[2];
        end
        if (en.s4) valid_next[4] = valid_reg[3];
        if (en.s5) valid_next[5] = valid_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            lower_limit_reg <= LOWER_RESET;
            upper_limit_reg <= UPPER_RESET;
        end else begin
            valid_reg       <= valid_next;
            lower_limit_reg <= lower_limit_next;
            upper_limit_reg <= upper_limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
    end

    // placement of both angles, stages 1 to 3
    lsad_place #(.TURN_BITS(TURN_BITS)) u_place_first (
        .aclk        (aclk),
        .en          (en),
        .angle_in    (s_tdata[ANGLE_WIDTH-1:0]),
        .lower_limit (lower_limit_reg),
        .upper_limit (upper_limit_reg),
        .angle_out   (first_placed)
    );

    lsad_place #(.TURN_BITS(TURN_BITS)) u_place_second (
        .aclk        (aclk),
        .en          (en),
        .angle_in    (s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .lower_limit (lower_limit_reg),
        .upper_limit (upper_limit_reg),
        .angle_out   (second_placed)
    );

    // difference and path choice, stages 4 and 5 (stage 5 is the output register)
    lsad_diff #(.TURN_BITS(TURN_BITS)) u_diff (
        .aclk          (aclk),
        .en            (en),
        .operation     (op_reg[3]),
        .first_placed  (first_placed),
        .second_placed (second_placed),
        .lower_limit   (lower_limit_reg),
        .upper_limit   (upper_limit_reg),
        .difference    (difference),
        .out_of_limits (out_of_limits)
    );

    assign s_tready = en.s1;
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {{(M_TDATA_WIDTH-DIFF_WIDTH){1'b0}}, difference};
    assign m_tuser  = out_of_limits;

endmodule

/* sv/lsad_checker.sv */
// port-level checker of the angle difference unit and its bind
`include "limited_shortest_angle_difference_unit_macros.svh"

module lsad_checker
    import lsad_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata,
    input logic [0:0]               m_tuser
);

    // a reset empties the pipeline
    `LSAD_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // an empty output stage means the whole pipeline can move
    `LSAD_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

    // an error result carries a zero difference
    `LSAD_ASSERT(a_error_zero, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "nonzero data on error")

    // a stalled result holds
    `LSAD_ASSERT(a_hold_on_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

endmodule

bind limited_shortest_angle_difference_unit lsad_checker u_lsad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
